// ===== design/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_ALWAYS(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error("tcc check failed");
`define TCC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tcc check failed");
`else
`define TCC_ASSERT_ALWAYS(lbl, ck, rs, prop)
`define TCC_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== design/tcc_pkg.sv =====
// shared widths, cell and distance result types for the cluster center unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tcc_pkg;
  localparam int COORD_W   = 16;
  localparam int LBL_W     = 6;
  localparam int SUM_W     = COORD_W + LBL_W;
  localparam int CNT_OUT_W = 7;
  localparam int LIM_W     = 16;
  localparam int SQ_W      = 2 * LIM_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [LBL_W-1:0]          label;
  } cell_t;

  typedef struct packed {
    logic             valid;
    logic             near;
    logic [LBL_W-1:0] label;
  } dist_res_t;
endpackage
`default_nettype wire

// ===== design/tcc_ifs.sv =====
// valid/ready channel interfaces for points in and cluster results out
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface tcc_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [tcc_pkg::COORD_W-1:0] coord_x;
  logic signed [tcc_pkg::COORD_W-1:0] coord_y;
  logic signed [tcc_pkg::COORD_W-1:0] coord_z;
  logic                               last_point;
  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface tcc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tcc_pkg::COORD_W-1:0]   center_x;
  logic signed [tcc_pkg::COORD_W-1:0]   center_y;
  logic signed [tcc_pkg::COORD_W-1:0]   center_z;
  logic [tcc_pkg::CNT_OUT_W-1:0]        member_count;
  logic                                 last_cluster;
  logic                                 points_dropped;
  modport source (output valid, center_x, center_y, center_z, member_count,
                  last_cluster, points_dropped, input ready);
  modport sink (input valid, center_x, center_y, center_z, member_count,
                last_cluster, points_dropped, output ready);
endinterface
`default_nettype wire

// ===== design/tcc_cell.sv =====
// one storage cell of the point ring: coordinates and cluster label
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tcc_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire tcc_pkg::cell_t d,
  output tcc_pkg::cell_t      q
);
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end
endmodule
`default_nettype wire

// ===== design/tcc_dist.sv =====
// pipelined squared distance test of a ring point against the new point
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tcc_dist (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire tcc_pkg::cell_t                     a,
  input  wire logic signed [tcc_pkg::COORD_W-1:0] px,
  input  wire logic signed [tcc_pkg::COORD_W-1:0] py,
  input  wire logic signed [tcc_pkg::COORD_W-1:0] pz,
  input  wire logic [tcc_pkg::SQ_W-1:0]           lim_sq,
  output tcc_pkg::dist_res_t                      res
);
  localparam int CW = tcc_pkg::COORD_W;
  localparam int QW = 2 * CW;

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] u,
                                              input logic signed [CW-1:0] v);
    logic signed [CW:0] d;
    d = (CW+1)'(u) - (CW+1)'(v);
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  logic                          v1, v2;
  logic [tcc_pkg::LBL_W-1:0]     l1, l2;
  logic [CW-1:0]                 mx, my, mz;
  logic [QW-1:0]                 sx, sy, sz;
  logic [QW+1:0]                 sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    l1 <= a.label;
    mx <= abs_diff(a.x, px);
    my <= abs_diff(a.y, py);
    mz <= abs_diff(a.z, pz);
    l2 <= l1;
    sx <= mx * mx;
    sy <= my * my;
    sz <= mz * mz;
  end

  assign sum       = (QW+2)'(sx) + (QW+2)'(sy) + (QW+2)'(sz);
  assign res.valid = v2;
  assign res.label = l2;
  assign res.near  = sum < (QW+2)'(lim_sq);
endmodule
`default_nettype wire

// ===== design/tcc_div.sv =====
// restoring divider, one quotient bit per cycle, truncates toward zero
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tcc_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [tcc_pkg::SUM_W-1:0]     dividend,
  input  wire logic [tcc_pkg::CNT_OUT_W-1:0]        divisor,
  output logic                                      done,
  output logic signed [tcc_pkg::COORD_W-1:0]        quotient
);
  localparam int SW   = tcc_pkg::SUM_W;
  localparam int DW   = tcc_pkg::CNT_OUT_W;
  localparam int BC_W = $clog2(SW);

  logic            busy, neg;
  logic [SW-1:0]   mag;
  logic [DW-1:0]   rem;
  logic [BC_W-1:0] bitcnt;
  logic [DW:0]     trial, diff;
  logic            ge;
  logic [SW-1:0]   quot_full;

  assign trial     = {rem, mag[SW-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign diff      = trial - {1'b0, divisor};
  assign quot_full = neg ? -mag : mag;
  assign quotient  = quot_full[tcc_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        bitcnt <= '0;
        rem    <= '0;
        neg    <= dividend[SW-1];
        mag    <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
      end else if (busy) begin
        rem    <= ge ? diff[DW-1:0] : trial[DW-1:0];
        mag    <= {mag[SW-2:0], ge};
        bitcnt <= bitcnt + 1'b1;
        if (bitcnt == BC_W'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/threshold_cluster_centers_unit.sv =====
// top level: ring of point cells, distance unit, three dividers, control
// depends on tcc_pkg, tcc_ifs, tcc_cell, tcc_dist, tcc_div, assert_macros.svh
//
// channel    dir  fields
// points     in   coord_x coord_y coord_z last_point
// clusters   out  center_x center_y center_z member_count last_cluster points_dropped
// limit_*    in   distance_limit write, one register
//
// a stored point takes a ring turn for the distance test, a drain of the
// distance pipeline, then a ring turn to relabel and store
// a last point then takes a ring turn per cluster index up to the last
// cluster, plus a division and an output per cluster
// a ring turn shifts the ring through all MAX_POINTS cells
// rst is synchronous; the ring cells need no clearing, since the count of stored points is reset
// a stalled output holds the sequencer in its output state
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module threshold_cluster_centers_unit #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        limit_we,
  input  wire logic [tcc_pkg::LIM_W-1:0]   limit_wdata,
  tcc_point_if.sink                        points,
  tcc_result_if.source                     clusters
);
  localparam int IW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(MAX_POINTS + 2);
  localparam int CW     = tcc_pkg::COORD_W;
  localparam int LW     = tcc_pkg::LBL_W;
  localparam int SW     = tcc_pkg::SUM_W;
  localparam int OW     = tcc_pkg::CNT_OUT_W;
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(MAX_POINTS - 1);
  localparam logic [STEP_W-1:0] DRAIN_STEP = STEP_W'(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0]  MAXC       = CNT_W'(MAX_POINTS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MERGE = 6'b000100,
    S_SUM   = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                    state;
  logic [STEP_W-1:0]         step;
  logic [CNT_W-1:0]          count;
  logic                      overflow;
  logic [tcc_pkg::LIM_W-1:0] limit;
  logic [tcc_pkg::SQ_W-1:0]  lim_sq;
  logic signed [CW-1:0]      px, py, pz;
  logic                      last_q;
  logic [MAX_POINTS-1:0]     hit;
  logic                      found;
  logic [LW-1:0]             parent;
  logic [IW-1:0]             lastroot, lcur;
  logic                      root;
  logic signed [SW-1:0]      acc_x, acc_y, acc_z;
  logic [OW-1:0]             mcnt;
  logic                      div_start;

  logic                      o_valid, o_last, o_drop;
  logic signed [CW-1:0]      o_x, o_y, o_z;
  logic [OW-1:0]             o_cnt;

  tcc_pkg::cell_t            cell_q [MAX_POINTS];
  tcc_pkg::cell_t            head, tail;
  logic                      rotate;
  tcc_pkg::dist_res_t        dres;
  logic                      dvx, dvy, dvz;
  logic signed [CW-1:0]      qx, qy, qz;

  logic step_in_set, root_now, emit_load, last_now;

  assign head        = cell_q[0];
  assign step_in_set = step < STEP_W'(count);
  assign rotate      = (state == S_SCAN && step <= LAST_STEP) || state == S_MERGE ||
                       state == S_SUM;
  assign root_now    = (step == STEP_W'(lcur)) ? (head.label == LW'(lcur)) : root;
  assign emit_load   = state == S_EMIT && (!o_valid || clusters.ready);
  assign last_now    = lcur == lastroot;

  always_comb begin
    tail = head;
    if (state == S_MERGE) begin
      if (step_in_set) begin
        if (found && hit[head.label[IW-1:0]]) begin
          tail.label = parent;
        end
      end else if (step == STEP_W'(count)) begin
        tail.x     = px;
        tail.y     = py;
        tail.z     = pz;
        tail.label = found ? parent : LW'(count);
      end
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    if (i == MAX_POINTS - 1) begin : g_tail
      tcc_cell u_cell (.clk(clk), .shift(rotate), .d(tail), .q(cell_q[i]));
    end else begin : g_mid
      tcc_cell u_cell (.clk(clk), .shift(rotate), .d(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  tcc_dist u_dist (
    .clk(clk), .rst(rst),
    .in_valid(state == S_SCAN && step_in_set),
    .a(head), .px(px), .py(py), .pz(pz), .lim_sq(lim_sq), .res(dres)
  );

  tcc_div u_div_x (.clk(clk), .rst(rst), .start(div_start), .dividend(acc_x),
                   .divisor(mcnt), .done(dvx), .quotient(qx));
  tcc_div u_div_y (.clk(clk), .rst(rst), .start(div_start), .dividend(acc_y),
                   .divisor(mcnt), .done(dvy), .quotient(qy));
  tcc_div u_div_z (.clk(clk), .rst(rst), .start(div_start), .dividend(acc_z),
                   .divisor(mcnt), .done(dvz), .quotient(qz));

  assign points.ready            = state == S_IDLE;
  assign clusters.valid          = o_valid;
  assign clusters.center_x       = o_x;
  assign clusters.center_y       = o_y;
  assign clusters.center_z       = o_z;
  assign clusters.member_count   = o_cnt;
  assign clusters.last_cluster   = o_last;
  assign clusters.points_dropped = o_drop;

  always_ff @(posedge clk) begin
    lim_sq <= limit * limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= '0;
      overflow  <= 1'b0;
      limit     <= tcc_pkg::LIM_W'(51);
      o_valid   <= 1'b0;
      div_start <= 1'b0;
      found     <= 1'b0;
      hit       <= '0;
      lastroot  <= '0;
      lcur      <= '0;
    end else begin
      div_start <= 1'b0;
      if (limit_we) begin
        limit <= limit_wdata;
      end
      if (o_valid && clusters.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (points.valid) begin
            px     <= points.coord_x;
            py     <= points.coord_y;
            pz     <= points.coord_z;
            last_q <= points.last_point;
            step   <= '0;
            if (count < MAXC) begin
              state <= S_SCAN;
              hit   <= '0;
              found <= 1'b0;
            end else begin
              overflow <= 1'b1;
              if (points.last_point) begin
                state <= S_SUM;
                lcur  <= '0;
                acc_x <= '0;
                acc_y <= '0;
                acc_z <= '0;
                mcnt  <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          if (dres.valid && dres.near) begin
            hit[dres.label[IW-1:0]] <= 1'b1;
            if (!found || dres.label < parent) begin
              parent <= dres.label;
            end
            found <= 1'b1;
          end
          if (step == DRAIN_STEP) begin
            state <= S_MERGE;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MERGE: begin
          if (step <= STEP_W'(count) && tail.label == LW'(step)) begin
            lastroot <= IW'(step);
          end
          if (step == LAST_STEP) begin
            count <= count + 1'b1;
            step  <= '0;
            if (last_q) begin
              state <= S_SUM;
              lcur  <= '0;
              acc_x <= '0;
              acc_y <= '0;
              acc_z <= '0;
              mcnt  <= '0;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SUM: begin
          if (step_in_set && head.label == LW'(lcur)) begin
            acc_x <= acc_x + SW'(head.x);
            acc_y <= acc_y + SW'(head.y);
            acc_z <= acc_z + SW'(head.z);
            mcnt  <= mcnt + 1'b1;
          end
          root <= root_now;
          if (step == LAST_STEP) begin
            step <= '0;
            if (root_now) begin
              state     <= S_DIV;
              div_start <= 1'b1;
            end else begin
              lcur  <= lcur + 1'b1;
              acc_x <= '0;
              acc_y <= '0;
              acc_z <= '0;
              mcnt  <= '0;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          if (dvx) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            o_valid <= 1'b1;
            o_x     <= qx;
            o_y     <= qy;
            o_z     <= qz;
            o_cnt   <= mcnt;
            o_last  <= last_now;
            o_drop  <= overflow;
            if (last_now) begin
              state    <= S_IDLE;
              count    <= '0;
              overflow <= 1'b0;
            end else begin
              state <= S_SUM;
              lcur  <= lcur + 1'b1;
              acc_x <= '0;
              acc_y <= '0;
              acc_z <= '0;
              mcnt  <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCC_ASSERT_ALWAYS(a_count_cap, clk, rst, count <= MAXC)
  `TCC_ASSERT_NEXT(a_last_clears, clk, rst, emit_load && last_now, state == S_IDLE && count == '0)
  `TCC_ASSERT_ALWAYS(a_parent_stored, clk, rst, !(state == S_MERGE && found) || parent < LW'(count))
  `TCC_ASSERT_ALWAYS(a_cluster_order, clk, rst, !(state == S_SUM) || lcur <= lastroot)
  `TCC_ASSERT_ALWAYS(a_div_lockstep, clk, rst, dvx == dvy && dvy == dvz)
endmodule
`default_nettype wire
